// ===== hw/rtl/pwad_pkg.sv =====
// Package for the proximity window average detector.
// Field widths, register indexes, request kinds and engine states.
// No dependencies.
package pwad_pkg;

	localparam int CH_W       = 3;
	localparam int SAMPLE_W   = 8;
	localparam int HOLD_W     = 10;
	localparam int REP_W      = 7;
	localparam int THR_W      = 4;
	localparam int FREF_W     = 6;
	localparam int REF_W      = 8;
	localparam int CAL_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_REF     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_CHANNEL   = 3'd4;

	localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 10'd400;
	localparam logic [REP_W-1:0]  REPEAT_RST    = 7'd1;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 4'd2;

	localparam logic [CAL_W-1:0]        CAL_MIN     = 8'd50;
	localparam logic [FREF_W-1:0]       FREF_LIMIT  = 6'd50;
	localparam logic signed [REF_W-1:0] DELTA_LIMIT = 8'sd10;

	localparam logic REQ_RESTART = 1'b1;

	typedef enum logic {
		K_SAMPLE,
		K_RESTART
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                ch_ok;
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] edge_count;
	} item_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_SUM,
		BE_MUL,
		BE_FIX,
		BE_DECIDE
	} be_state_t;

endpackage

// ===== hw/rtl/proximity_window_average_detector.sv =====
// Each word passes through states SUM and DECIDE with a power-of-two WINDOW, else SUM, MUL,
// FIX and DECIDE. The next word is popped only when the last commits; this is set by the
// ring memory read-modify-write and the shared reference updated at the end of each word.
// A 4-word queue lets the input side keep accepting while the result side stalls.
// Reset: asynchronous; clears control, per-channel sums, positions and counters, and
// the reference. The ring memory is not swept; a slot reads as zero until its ring wraps.
module proximity_window_average_detector #(
	parameter int CHANNELS = 8,
	parameter int WINDOW   = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic                               req_type,
	input  logic [pwad_pkg::CH_W-1:0]          channel,
	input  logic [pwad_pkg::SAMPLE_W-1:0]      edge_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pwad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pwad_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [pwad_pkg::CH_W-1:0]          out_channel,
	output logic [pwad_pkg::SAMPLE_W-1:0]      average,
	output logic [pwad_pkg::HOLD_W-1:0]        hold_level,
	output logic                               detected,
	output logic                               running,
	output logic [pwad_pkg::REF_W-1:0]         reference_level
);
	import pwad_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	pwad_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.req_type    (req_type),
		.channel     (channel),
		.edge_count  (edge_count),
		.q_pop       (q_pop),
		.q_valid     (q_valid),
		.q_item      (q_item)
	);

	pwad_back #(
		.CHANNELS(CHANNELS),
		.WINDOW  (WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_channel    (out_channel),
		.average        (average),
		.hold_level     (hold_level),
		.detected       (detected),
		.running        (running),
		.reference_level(reference_level)
	);

	a_stall_means_queued: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> q_valid)
		else $error("input stalled with empty queue");

	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_detect_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (detected == (hold_level != '0)))
		else $error("detected does not match hold level");

	a_running_ref: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (running == (reference_level != '0)))
		else $error("running does not match reference level");

endmodule

// ===== hw/rtl/pwad_front.sv =====
// Front end: accepts words, classifies them and queues them for the engine.
// Depends on pwad_pkg.
module pwad_front #(
	parameter int CHANNELS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic                               req_type,
	input  logic [pwad_pkg::CH_W-1:0]          channel,
	input  logic [pwad_pkg::SAMPLE_W-1:0]      edge_count,
	input  logic                               q_pop,
	output logic                               q_valid,
	output pwad_pkg::item_t                    q_item
);
	import pwad_pkg::*;

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	item_t             in_item;
	logic              push;
	logic              pop;

	assign sample_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid      = (cnt_q != '0);
	assign q_item       = fifo_q[rd_ptr_q];
	assign push         = sample_valid && !sample_stall;
	assign pop          = q_pop && q_valid;

	always_comb begin
		in_item.kind       = (req_type == REQ_RESTART) ? K_RESTART : K_SAMPLE;
		in_item.ch_ok      = (32'(channel) < CHANNELS);
		in_item.channel    = channel;
		in_item.edge_count = edge_count;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/pwad_back.sv =====
// Back end: ring memory, window sums, averaging, detection and result register.
// Holds the configuration registers and the shared reference.
// Depends on pwad_pkg.
module pwad_back #(
	parameter int CHANNELS = 8,
	parameter int WINDOW   = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  pwad_pkg::item_t                    q_item,
	output logic                               q_pop,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pwad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pwad_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [pwad_pkg::CH_W-1:0]          out_channel,
	output logic [pwad_pkg::SAMPLE_W-1:0]      average,
	output logic [pwad_pkg::HOLD_W-1:0]        hold_level,
	output logic                               detected,
	output logic                               running,
	output logic [pwad_pkg::REF_W-1:0]         reference_level
);
	import pwad_pkg::*;

	localparam int   CIDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int   POS_W     = $clog2(WINDOW);
	localparam int   ADDR_W    = CIDX_W + POS_W;
	localparam int   MEM_DEPTH = CHANNELS << POS_W;
	localparam int   SUM_W     = SAMPLE_W + POS_W;
	localparam int   NUM_W     = SUM_W + 1;
	localparam int   HALF      = WINDOW / 2;
	localparam logic IS_POW2   = ((WINDOW & (WINDOW - 1)) == 0);

	be_state_t            state_q;
	be_state_t            state_nxt;

	logic [SAMPLE_W-1:0]  ring_mem [MEM_DEPTH];
	logic [POS_W-1:0]     pos_q    [CHANNELS];
	logic                 full_q   [CHANNELS];
	logic [SUM_W-1:0]     sum_q    [CHANNELS];
	logic [REP_W-1:0]     hit_q    [CHANNELS];
	logic [HOLD_W-1:0]    hold_q   [CHANNELS];
	logic [REF_W-1:0]     ref_q;
	logic [CAL_W-1:0]     cal_q;
	logic [HOLD_W-1:0]    hold_time_q;
	logic [REP_W-1:0]     repeat_q;
	logic [THR_W-1:0]     thr_q;
	logic [CH_W-1:0]      refch_q;

	item_t                item_s1;
	logic [SAMPLE_W-1:0]  rd_s1;
	logic                 full_s1;
	logic [NUM_W-1:0]     num_s2;
	logic [SAMPLE_W-1:0]  avg;

	logic                 res_valid_q;
	logic [CH_W-1:0]      res_ch_q;
	logic [SAMPLE_W-1:0]  res_avg_q;
	logic [HOLD_W-1:0]    res_hold_q;
	logic [REF_W-1:0]     res_ref_q;

	logic [CIDX_W-1:0]    pop_cidx;
	logic [ADDR_W-1:0]    rd_addr;
	logic [CIDX_W-1:0]    cidx;
	logic [ADDR_W-1:0]    wr_addr;
	logic                 is_sample;
	logic [SAMPLE_W-1:0]  old_sample;
	logic [NUM_W-1:0]     sum_upd;
	logic [SUM_W-1:0]     sum_cur;
	logic                 out_free;
	logic                 commit;

	logic [HOLD_W-1:0]    hold_cur;
	logic [HOLD_W-1:0]    hold_dec;
	logic [REP_W-1:0]     hit_cnt;
	logic signed [REF_W-1:0] delta;
	logic [CAL_W-1:0]     cal_inc;
	logic [REF_W-1:0]     ref_nxt;
	logic [CAL_W-1:0]     cal_nxt;
	logic [CH_W-1:0]      refch_nxt;
	logic [REP_W-1:0]     hit_nxt;
	logic [HOLD_W-1:0]    hold_nxt;
	logic [SAMPLE_W-1:0]  avg_res;
	logic [HOLD_W-1:0]    hold_res;
	logic                 upd_ch;
	logic [FREF_W-1:0]    fref;

	assign cfg_ready = 1'b1;

	assign pop_cidx = CIDX_W'(q_item.channel);
	assign rd_addr  = {pop_cidx, pos_q[pop_cidx]};
	assign cidx     = CIDX_W'(item_s1.channel);
	assign wr_addr  = {cidx, pos_q[cidx]};

	assign is_sample  = (item_s1.kind == K_SAMPLE) && item_s1.ch_ok;
	assign old_sample = full_s1 ? rd_s1 : '0;
	assign sum_upd    = NUM_W'(sum_q[cidx]) + NUM_W'(item_s1.edge_count) - NUM_W'(old_sample);
	assign sum_cur    = is_sample ? SUM_W'(sum_upd) : sum_q[cidx];

	assign out_free = !res_valid_q || !result_stall;
	assign commit   = (state_q == BE_DECIDE) && out_free;
	assign q_pop    = q_valid && ((state_q == BE_IDLE) || commit);

	// divide the rounded sum by the window length
	generate
		if (IS_POW2) begin : g_shift
			assign avg = num_s2[POS_W +: SAMPLE_W];
		end else begin : g_recip
			localparam int K      = NUM_W;
			localparam int PROD_W = 2 * NUM_W;
			localparam int RECIP  = (2 ** K) / WINDOW;

			logic [PROD_W-1:0]   prod_s3;
			logic [SAMPLE_W-1:0] avg_s4;
			logic [SAMPLE_W-1:0] q_est;
			logic [NUM_W-1:0]    rem;

			assign q_est = prod_s3[K +: SAMPLE_W];
			assign rem   = num_s2 - NUM_W'(32'(q_est) * WINDOW);
			assign avg   = avg_s4;

			always_ff @(posedge clk) begin
				if (state_q == BE_MUL) begin
					prod_s3 <= PROD_W'(num_s2) * PROD_W'(NUM_W'(RECIP));
				end
				if (state_q == BE_FIX) begin
					avg_s4 <= (rem >= NUM_W'(WINDOW)) ? q_est + 1'b1 : q_est;
				end
			end
		end
	endgenerate

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BE_IDLE: begin
				if (q_valid) begin
					state_nxt = BE_SUM;
				end
			end
			BE_SUM: begin
				state_nxt = IS_POW2 ? BE_DECIDE : BE_MUL;
			end
			BE_MUL: begin
				state_nxt = BE_FIX;
			end
			BE_FIX: begin
				state_nxt = BE_DECIDE;
			end
			BE_DECIDE: begin
				if (out_free) begin
					state_nxt = q_valid ? BE_SUM : BE_IDLE;
				end
			end
			default: begin
				state_nxt = BE_IDLE;
			end
		endcase
	end

	assign hold_cur = hold_q[cidx];
	assign hold_dec = (hold_cur != '0) ? hold_cur - 1'b1 : hold_cur;
	assign hit_cnt  = hit_q[cidx];
	assign delta    = $signed(ref_q - avg);
	assign cal_inc  = cal_q + 1'b1;

	always_comb begin
		ref_nxt   = ref_q;
		cal_nxt   = cal_q;
		refch_nxt = refch_q;
		hit_nxt   = hit_cnt;
		hold_nxt  = hold_cur;
		avg_res   = avg;
		hold_res  = hold_cur;
		upd_ch    = 1'b0;
		if (item_s1.kind == K_RESTART) begin
			ref_nxt   = '0;
			cal_nxt   = '0;
			refch_nxt = item_s1.channel;
			if (!item_s1.ch_ok) begin
				avg_res  = '0;
				hold_res = '0;
			end
		end else if (!item_s1.ch_ok) begin
			avg_res  = '0;
			hold_res = '0;
		end else begin
			upd_ch   = 1'b1;
			hold_nxt = hold_dec;
			if (ref_q == '0) begin
				if (item_s1.channel == refch_q) begin
					cal_nxt = cal_inc;
					if (cal_inc > CAL_MIN) begin
						ref_nxt = avg;
					end
				end
			end else begin
				if (delta < $signed({4'b0000, thr_q})) begin
					hit_nxt = '0;
				end else if (hit_cnt < repeat_q) begin
					hit_nxt = hit_cnt + 1'b1;
				end
				if ((hit_cnt == repeat_q) && (delta < DELTA_LIMIT)) begin
					hold_nxt = hold_time_q;
				end
			end
			hold_res = hold_nxt;
		end
	end

	assign fref = cfg_data[FREF_W-1:0];

	always_ff @(posedge clk) begin
		if (state_q == BE_SUM && is_sample) begin
			ring_mem[wr_addr] <= item_s1.edge_count;
		end
		if (q_pop) begin
			rd_s1 <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			full_s1 <= full_q[pop_cidx];
		end
		if (state_q == BE_SUM) begin
			num_s2 <= NUM_W'(sum_cur) + NUM_W'(HALF);
		end
		if (commit) begin
			res_ch_q   <= item_s1.channel;
			res_avg_q  <= avg_res;
			res_hold_q <= hold_res;
			res_ref_q  <= ref_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			res_valid_q <= 1'b0;
			ref_q       <= '0;
			cal_q       <= '0;
			hold_time_q <= HOLD_TIME_RST;
			repeat_q    <= REPEAT_RST;
			thr_q       <= THRESHOLD_RST;
			refch_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				full_q[i] <= 1'b0;
				sum_q[i]  <= '0;
				hit_q[i]  <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == BE_SUM && is_sample) begin
				sum_q[cidx] <= sum_cur;
				if (pos_q[cidx] == POS_W'(WINDOW - 1)) begin
					pos_q[cidx]  <= '0;
					full_q[cidx] <= 1'b1;
				end else begin
					pos_q[cidx] <= pos_q[cidx] + 1'b1;
				end
			end
			if (commit) begin
				ref_q   <= ref_nxt;
				cal_q   <= cal_nxt;
				refch_q <= refch_nxt;
				if (upd_ch) begin
					hit_q[cidx]  <= hit_nxt;
					hold_q[cidx] <= hold_nxt;
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_HOLD_TIME: begin
						hold_time_q <= cfg_data[HOLD_W-1:0];
					end
					REG_REPEAT_COUNT: begin
						repeat_q <= cfg_data[REP_W-1:0];
					end
					REG_THRESHOLD: begin
						thr_q <= cfg_data[THR_W-1:0];
					end
					REG_FIXED_REF: begin
						if (fref == '0) begin
							ref_q <= '0;
							cal_q <= '0;
						end else if (fref < FREF_LIMIT) begin
							ref_q <= REF_W'(fref);
						end
					end
					REG_REF_CHANNEL: begin
						refch_q <= cfg_data[CH_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result_valid    = res_valid_q;
	assign out_channel     = res_ch_q;
	assign average         = res_avg_q;
	assign hold_level      = res_hold_q;
	assign detected        = (res_hold_q != '0);
	assign running         = (res_ref_q != '0);
	assign reference_level = res_ref_q;

endmodule
